>>> rtl/core/scfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_pkg
// Shared types and codes of the set-cover fitness evaluator.
// ----------------------------------------------------------------------------
package scfe_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_LOAD_ROW  = 2'd0;
  localparam logic [1:0] REQ_WRITE_SEL = 2'd1;
  localparam logic [1:0] REQ_FULL_EVAL = 2'd2;
  localparam logic [1:0] REQ_FLIP_EVAL = 2'd3;

  // Configuration register indexes.
  localparam logic REG_ROWS_IN_USE    = 1'b0;
  localparam logic REG_COLUMNS_IN_USE = 1'b1;

  // Field widths of the streams.
  localparam int REQ_W      = 2;
  localparam int ROW_IDX_W  = 8;
  localparam int ROW_BITS_W = 64;
  localparam int COL_IDX_W  = 6;
  localparam int ROWS_W     = 9;
  localparam int COLS_W     = 7;
  localparam int FIT_W      = 9;
  localparam int UNC_W      = 9;
  localparam int CHOSEN_W   = 7;
  localparam int CFG_DATA_W = 9;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_row;
    logic write_sel;
    logic start_eval;
    logic flip;
    logic walk;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/scfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_ctrl
// Sequencer: takes requests, runs the row walk and hands results to output.
// ----------------------------------------------------------------------------
module scfe_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic [scfe_pkg::REQ_W-1:0] req_type,
  output logic                      s_tready,
  input  scfe_pkg::status_t         status,
  output scfe_pkg::cmd_t            cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (req_type)
            scfe_pkg::REQ_LOAD_ROW: begin
              cmd.load_row = 1'b1;
            end
            scfe_pkg::REQ_WRITE_SEL: begin
              cmd.write_sel = 1'b1;
            end
            scfe_pkg::REQ_FULL_EVAL: begin
              cmd.start_eval = 1'b1;
              state_next     = ST_RUN;
            end
            scfe_pkg::REQ_FLIP_EVAL: begin
              cmd.start_eval = 1'b1;
              cmd.flip       = 1'b1;
              state_next     = ST_RUN;
            end
          endcase
        end
      end
      ST_RUN: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/scfe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_datapath
// Row memory, selection vector, coverage counters and the output register.
// ----------------------------------------------------------------------------
module scfe_datapath #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [scfe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [scfe_pkg::ROW_IDX_W-1:0]     row_index,
  input  logic [scfe_pkg::ROW_BITS_W-1:0]    row_bits,
  input  logic [scfe_pkg::COL_IDX_W-1:0]     column_index,
  input  logic                               bit_value,
  input  scfe_pkg::cmd_t                     cmd,
  output scfe_pkg::status_t                  status,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [scfe_pkg::FIT_W-1:0]         fitness,
  output logic [scfe_pkg::UNC_W-1:0]         uncovered_count,
  output logic [scfe_pkg::CHOSEN_W-1:0]      chosen_count,
  output logic                               feasible
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int LW = (CW > scfe_pkg::ROWS_W) ? CW : scfe_pkg::ROWS_W;
  localparam int PW = ((MAX_COLUMNS + 7) / 8) * 8;

  logic [scfe_pkg::ROWS_W-1:0]   rows_in_use;
  logic [scfe_pkg::COLS_W-1:0]   columns_in_use;
  logic [MAX_COLUMNS-1:0]        sel;
  logic [MAX_COLUMNS-1:0]        chosen;
  logic [PW-1:0]                 pop_sh;
  logic [scfe_pkg::CHOSEN_W-1:0] chosen_acc;
  logic [LW-1:0]                 ptr;
  logic [LW-1:0]                 rows_lim;
  logic [scfe_pkg::UNC_W-1:0]    uncovered;
  logic                          rd_valid;
  logic [MAX_COLUMNS-1:0]        rd_data;
  logic [MAX_COLUMNS-1:0]        mem [MAX_ROWS];

  logic [MAX_COLUMNS-1:0]        col_hit;
  logic [MAX_COLUMNS-1:0]        col_mask;
  logic [MAX_COLUMNS-1:0]        eval_sel;
  logic [LW-1:0]                 rows_sat;
  logic [LW-1:0]                 row_addr;
  logic                          row_ok;
  logic                          issue;
  logic [3:0]                    pop8;
  logic [scfe_pkg::FIT_W:0]      sum;
  logic [scfe_pkg::FIT_W-1:0]    fitness_sat;

  always_comb begin
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      col_hit[j]  = (column_index == scfe_pkg::COL_IDX_W'(j));
      col_mask[j] = (scfe_pkg::COLS_W'(j) < columns_in_use);
    end
  end

  assign eval_sel = (sel ^ (cmd.flip ? col_hit : '0)) & col_mask;
  assign rows_sat = (LW'(rows_in_use) > LW'(MAX_ROWS)) ? LW'(MAX_ROWS) : LW'(rows_in_use);
  assign row_addr = LW'(row_index);
  assign row_ok   = (row_addr < LW'(MAX_ROWS));
  assign issue    = cmd.walk && (ptr != rows_lim);

  always_comb begin
    pop8 = '0;
    for (int k = 0; k < 8; k++) begin
      pop8 = pop8 + 4'(pop_sh[k]);
    end
  end

  assign sum         = (scfe_pkg::FIT_W + 1)'(uncovered) + (scfe_pkg::FIT_W + 1)'(chosen_acc);
  assign fitness_sat = sum[scfe_pkg::FIT_W] ? '1 : sum[scfe_pkg::FIT_W-1:0];

  assign status.walk_done = (ptr == rows_lim) && !rd_valid && (pop_sh == '0);
  assign status.out_free  = !m_tvalid || m_tready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= scfe_pkg::ROWS_W'(256);
      columns_in_use <= scfe_pkg::COLS_W'(64);
      sel            <= '0;
      rd_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          scfe_pkg::REG_ROWS_IN_USE:    rows_in_use    <= cfg_data;
          scfe_pkg::REG_COLUMNS_IN_USE: columns_in_use <= cfg_data[scfe_pkg::COLS_W-1:0];
        endcase
      end
      if (cmd.write_sel) begin
        for (int j = 0; j < MAX_COLUMNS; j++) begin
          if (col_hit[j]) begin
            sel[j] <= bit_value;
          end
        end
      end
      if (cmd.start_eval) begin
        rd_valid <= 1'b0;
      end else if (cmd.walk) begin
        rd_valid <= issue;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Row memory: written by loads, read one row per cycle during the walk.
  always_ff @(posedge clk) begin
    if (cmd.load_row && row_ok) begin
      mem[row_addr[AW-1:0]] <= row_bits[MAX_COLUMNS-1:0];
    end
    if (issue) begin
      rd_data <= mem[ptr[AW-1:0]];
    end
  end

  // Walk counters and the output register.
  always_ff @(posedge clk) begin
    if (cmd.start_eval) begin
      chosen     <= eval_sel;
      pop_sh     <= PW'(eval_sel);
      chosen_acc <= '0;
      ptr        <= '0;
      rows_lim   <= rows_sat;
      uncovered  <= '0;
    end else if (cmd.walk) begin
      pop_sh     <= pop_sh >> 8;
      chosen_acc <= chosen_acc + scfe_pkg::CHOSEN_W'(pop8);
      if (issue) begin
        ptr <= ptr + 1'b1;
      end
      if (rd_valid && ((rd_data & chosen) == '0)) begin
        uncovered <= uncovered + 1'b1;
      end
    end
    if (cmd.finish) begin
      fitness         <= fitness_sat;
      uncovered_count <= uncovered;
      chosen_count    <= chosen_acc;
      feasible        <= (uncovered == '0);
    end
  end

endmodule

>>> rtl/core/set_cover_fitness_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_cover_fitness_evaluator
// Scores set-cover selections against a stored incidence matrix.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Contents
// s_*       in   request word: tuser = kind, tdata = row, bits, column, value
// m_*       out  result word: fitness, uncovered, chosen, feasible
// cfg_*     in   register write: 0 rows_in_use, 1 columns_in_use
//
// A row load or a selection write returns no word.
// An evaluation walks the saturated row count of rows before it raises the
// result valid. With fewer than seven rows the chosen-subset count, summed
// eight bits per cycle alongside the walk, sets when the result is raised.
// The next request can be taken in the cycle the result is raised.
// Reset clears the selection vector and sets the registers to 256 rows and
// 64 columns; matrix rows hold nothing defined until they are loaded.
// A finished result sits in the output register; new requests are taken
// while it waits, and only the next evaluation's hand-off stalls on it.
//
module set_cover_fitness_evaluator #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // Fields from bit 0: row_index[7:0], row_bits[71:8], column_index[77:72],
  // bit_value[78], zero fill[79].
  input  logic [scfe_pkg::IN_DATA_W-1:0]     s_tdata,
  // Fields from bit 0: req_type[1:0].
  input  logic [scfe_pkg::REQ_W-1:0]         s_tuser,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: fitness[8:0], uncovered_count[17:9],
  // chosen_count[24:18], feasible[25], zero fill[31:26].
  output logic [scfe_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [scfe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  scfe_pkg::cmd_t    cmd;
  scfe_pkg::status_t status;

  logic [scfe_pkg::FIT_W-1:0]    fitness;
  logic [scfe_pkg::UNC_W-1:0]    uncovered_count;
  logic [scfe_pkg::CHOSEN_W-1:0] chosen_count;
  logic                          feasible;

  scfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .req_type (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  scfe_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .row_index       (s_tdata[7:0]),
    .row_bits        (s_tdata[71:8]),
    .column_index    (s_tdata[77:72]),
    .bit_value       (s_tdata[78]),
    .cmd             (cmd),
    .status          (status),
    .m_tready        (m_tready),
    .m_tvalid        (m_tvalid),
    .fitness         (fitness),
    .uncovered_count (uncovered_count),
    .chosen_count    (chosen_count),
    .feasible        (feasible)
  );

  assign m_tdata = {6'b0, feasible, chosen_count, uncovered_count, fitness};

endmodule

>>> rtl/core/scfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_checker
// Port-level checks on the result stream of the fitness evaluator.
// ----------------------------------------------------------------------------
module scfe_checker (
  input logic                            clk,
  input logic                            rst,
  input logic [scfe_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready
);

  logic [8:0] fit;
  logic [8:0] unc;
  logic [6:0] chosen;
  logic       feas;
  logic [9:0] sum;
  logic [8:0] fit_expect;

  assign fit        = m_tdata[8:0];
  assign unc        = m_tdata[17:9];
  assign chosen     = m_tdata[24:18];
  assign feas       = m_tdata[25];
  assign sum        = {1'b0, unc} + {3'b0, chosen};
  assign fit_expect = sum[9] ? 9'd511 : sum[8:0];

  // A stalled result word stays offered and unchanged.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result word changed while stalled");

  // The fitness is the saturated sum of its two parts.
  a_fitness_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> fit == fit_expect)
    else $error("fitness does not match its parts");

  // Feasibility agrees with the uncovered count, and no more than 64 chosen.
  a_feasible: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (feas == (unc == 9'd0)) && (chosen <= 7'd64))
    else $error("feasible flag or chosen count inconsistent");

endmodule

bind set_cover_fitness_evaluator scfe_checker u_scfe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

>>> bench/set_cover_fitness_evaluator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_cover_fitness_evaluator_test
// Self-checking bench for the set-cover fitness evaluator.
// ----------------------------------------------------------------------------
// Every request word is mirrored into a local copy of the incidence matrix,
// the selection vector and the two size registers at the edge where it is
// taken. Each evaluation request queues the score that this copy predicts,
// and every result word is compared field by field with the oldest queued
// score. A short directed part covers the size extremes and the coverage
// corner cases. It is followed by random phases at many instance sizes with
// random idling on both streams, one long output stall and pauses that
// drain all pending scores.
// ----------------------------------------------------------------------------
module set_cover_fitness_evaluator_test;
  import scfe_pkg::*;

  localparam int CLK_PERIOD       = 4;
  localparam int ROW_SLOTS        = 256;
  localparam int COLUMN_SLOTS     = 64;
  // Longer than the longest evaluation, so this covers any work in flight.
  localparam int SETTLE_CYCLES    = 300;
  localparam int LONG_HOLD_CYCLES = 800;
  localparam int RANDOM_ITEMS     = 100;

  // One predicted result word.
  typedef struct packed {
    logic [FIT_W-1:0]    fitness;
    logic [UNC_W-1:0]    uncovered;
    logic [CHOSEN_W-1:0] chosen;
    logic                feasible;
  } score_t;

  logic clk = 1'b0;
  logic rst;

  // Fields from bit 0: row_index[7:0], row_bits[71:8], column_index[77:72],
  // bit_value[78], zero fill[79].
  logic [IN_DATA_W-1:0]  s_tdata;
  // Fields from bit 0: req_type[1:0].
  logic [REQ_W-1:0]      s_tuser;
  logic                  s_tvalid;
  logic                  s_tready;
  // Fields from bit 0: fitness[8:0], uncovered_count[17:9],
  // chosen_count[24:18], feasible[25], zero fill[31:26].
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Local copy of the block's state, updated as words are accepted.
  logic [ROW_BITS_W-1:0] matrix_rows [ROW_SLOTS];
  logic [COLUMN_SLOTS-1:0] selected_columns;
  logic [ROWS_W-1:0]     cfg_rows;
  logic [COLS_W-1:0]     cfg_cols;

  score_t pending_scores [$];

  // Traffic shaping, set by the test tasks.
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;
  bit hold_request = 1'b0;

  int fail_count     = 0;
  int requests_sent  = 0;
  int scores_checked = 0;
  int random_items   = 0;
  int sizes_tried    = 0;

  set_cover_fitness_evaluator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register values above the storage size saturate, as in the block.
  function automatic int rows_effective();
    return (cfg_rows > ROW_SLOTS) ? ROW_SLOTS : int'(cfg_rows);
  endfunction

  function automatic int cols_effective();
    return (cfg_cols > COLUMN_SLOTS) ? COLUMN_SLOTS : int'(cfg_cols);
  endfunction

  // Scores a selection against the rows and columns currently in use.
  function automatic score_t score_selection(logic [COLUMN_SLOTS-1:0] sel);
    logic [COLUMN_SLOTS-1:0] in_use;
    logic [COLUMN_SLOTS-1:0] picked;
    int cols;
    int uncovered_n;
    int chosen_n;
    int fit;
    score_t s;
    cols = cols_effective();
    in_use = (cols >= COLUMN_SLOTS) ? '1 : ((64'd1 << cols) - 64'd1);
    picked = sel & in_use;
    chosen_n = $countones(picked);
    uncovered_n = 0;
    for (int r = 0; r < rows_effective(); r++) begin
      if ((matrix_rows[r] & picked) == '0) uncovered_n++;
    end
    fit = chosen_n + uncovered_n;
    if (fit > 511) fit = 511;
    s.fitness   = fit[FIT_W-1:0];
    s.uncovered = uncovered_n[UNC_W-1:0];
    s.chosen    = chosen_n[CHOSEN_W-1:0];
    s.feasible  = (uncovered_n == 0);
    return s;
  endfunction

  // Appends one predicted score behind those already waiting.
  function automatic void queue_score(score_t s);
    pending_scores = {pending_scores, s};
  endfunction

  // Applies one accepted request to the local state; an evaluation queues its score.
  function automatic void apply_request(logic [REQ_W-1:0] kind,
                                        logic [ROW_IDX_W-1:0] row_idx,
                                        logic [ROW_BITS_W-1:0] row_value,
                                        logic [COL_IDX_W-1:0] col_idx,
                                        logic bit_val);
    case (kind)
      REQ_LOAD_ROW:  matrix_rows[row_idx] = row_value;
      REQ_WRITE_SEL: selected_columns[col_idx] = bit_val;
      REQ_FULL_EVAL: queue_score(score_selection(selected_columns));
      REQ_FLIP_EVAL: begin
        queue_score(score_selection(selected_columns ^ (64'd1 << col_idx)));
      end
      default: ;
    endcase
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Row contents with a mix of densities. Dense random rows alone would
  // leave nearly every element covered, so sparse rows dominate.
  function automatic logic [ROW_BITS_W-1:0] random_row(int span);
    logic [ROW_BITS_W-1:0] value;
    value = '0;
    case ($urandom_range(0, 9))
      0: value = '0;
      1: value = '1;
      2, 3, 4, 5: value[$urandom_range(0, span - 1)] = 1'b1;
      6, 7: repeat (3) value[$urandom_range(0, span - 1)] = 1'b1;
      default: value = {$urandom, $urandom};
    endcase
    return value;
  endfunction

  // Offers one request word and returns at the edge where it is taken.
  // The valid stays high when the next word follows without a gap.
  task automatic send_word(input logic [REQ_W-1:0] kind,
                           input logic [ROW_IDX_W-1:0] row_idx,
                           input logic [ROW_BITS_W-1:0] row_value,
                           input logic [COL_IDX_W-1:0] col_idx,
                           input logic bit_val);
    int gap;
    gap = tx_gaps_on ? idle_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, bit_val, col_idx, row_value, row_idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_request(kind, row_idx, row_value, col_idx, bit_val);
    requests_sent++;
  endtask

  // Stops offering words and waits until every queued score has been checked.
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  // Writes both size registers once the block has gone quiet. Loads and
  // selection writes return no word, so a settle time follows the drain.
  task automatic set_instance_size(input logic [ROWS_W-1:0] rows_value,
                                   input logic [COLS_W-1:0] cols_value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_IN_USE;
    cfg_data  <= rows_value;
    @(negedge clk);
    cfg_index <= REG_COLUMNS_IN_USE;
    cfg_data  <= {{(CFG_DATA_W - COLS_W){1'b0}}, cols_value};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_rows = rows_value;
    cfg_cols = cols_value;
    sizes_tried++;
  endtask

  // Reset sizes: all 256 rows are in use, so every row is loaded before the
  // first evaluation. Every later phase then reads loaded rows only.
  task automatic test_reset_values();
    logic [ROW_BITS_W-1:0] row_value;
    for (int r = 0; r < ROW_SLOTS; r++) begin
      if (r == 0) row_value = '1;
      else if (r == ROW_SLOTS - 1) row_value = 64'h8000_0000_0000_0000;
      else row_value = random_row(COLUMN_SLOTS);
      send_word(REQ_LOAD_ROW, r[ROW_IDX_W-1:0], row_value, '0, 1'b0);
    end
    // Empty selection: every row is uncovered.
    send_word(REQ_FULL_EVAL, '0, '0, '0, 1'b0);
    send_word(REQ_FLIP_EVAL, '0, '0, 6'd63, 1'b0);
  endtask

  // Four rows whose coverage depends on the lowest and highest column.
  task automatic test_coverage_corners();
    set_instance_size(9'd4, 7'd64);
    send_word(REQ_LOAD_ROW, 8'd0, '1, '0, 1'b0);
    send_word(REQ_LOAD_ROW, 8'd1, 64'h8000_0000_0000_0000, '0, 1'b0);
    send_word(REQ_LOAD_ROW, 8'd2, 64'h0000_0000_0000_0001, '0, 1'b0);
    send_word(REQ_LOAD_ROW, 8'd3, 64'h8000_0000_0000_0001, '0, 1'b0);
    send_word(REQ_WRITE_SEL, '0, '0, 6'd0, 1'b1);
    send_word(REQ_FULL_EVAL, '0, '0, '0, 1'b0);
    // Flipping in the top column covers row 1 without committing it.
    send_word(REQ_FLIP_EVAL, '0, '0, 6'd63, 1'b0);
    send_word(REQ_WRITE_SEL, '0, '0, 6'd63, 1'b1);
    send_word(REQ_FULL_EVAL, '0, '0, '0, 1'b0);
    send_word(REQ_WRITE_SEL, '0, '0, 6'd0, 1'b0);
    send_word(REQ_FULL_EVAL, '0, '0, '0, 1'b0);
    // Flipping a chosen column drops it from the selection.
    send_word(REQ_FLIP_EVAL, '0, '0, 6'd63, 1'b0);
    send_word(REQ_WRITE_SEL, '0, '0, 6'd63, 1'b0);
    send_word(REQ_FULL_EVAL, '0, '0, '0, 1'b0);
  endtask

  // Size registers at zero, at their storage limits and beyond them.
  task automatic test_count_limits();
    send_word(REQ_WRITE_SEL, '0, '0, 6'd2, 1'b1);
    // No rows in use: nothing is uncovered and the selection is feasible.
    set_instance_size(9'd0, 7'd64);
    send_word(REQ_FULL_EVAL, '0, '0, '0, 1'b0);
    // Both registers above the storage size saturate.
    set_instance_size(9'd511, 7'd127);
    send_word(REQ_FULL_EVAL, '0, '0, '0, 1'b0);
    send_word(REQ_FLIP_EVAL, '0, '0, 6'd0, 1'b0);
    // No columns in use: nothing is chosen and a flip changes nothing.
    set_instance_size(9'd256, 7'd0);
    send_word(REQ_FULL_EVAL, '0, '0, '0, 1'b0);
    send_word(REQ_FLIP_EVAL, '0, '0, 6'd5, 1'b0);
    // One row, one column: a flip of the column in use, then one outside it that changes nothing.
    set_instance_size(9'd1, 7'd1);
    send_word(REQ_FLIP_EVAL, '0, '0, 6'd0, 1'b0);
    send_word(REQ_FLIP_EVAL, '0, '0, 6'd40, 1'b0);
  endtask

  // The receiver holds off for a long stretch while evaluations keep coming,
  // so the output register fills and the block stalls its input.
  task automatic test_output_stall();
    set_instance_size(9'd8, 7'd16);
    tx_gaps_on   = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_word((i % 2 == 0) ? REQ_FULL_EVAL : REQ_FLIP_EVAL, '0, '0,
                COL_IDX_W'($urandom_range(0, 15)), 1'b0);
    end
    wait_for_results();
    tx_gaps_on = 1'b1;
  endtask

  // One random phase: pick a size, maybe sweep the selection, then a mix of
  // loads, selection writes and both evaluation kinds.
  task automatic run_random_phase();
    logic [ROWS_W-1:0] rows_value;
    logic [COLS_W-1:0] cols_value;
    int span;
    int row_span;
    int density;
    int count;
    int pick;
    int col;
    case ($urandom_range(0, 9))
      0: rows_value = 9'd256;
      1: rows_value = ROWS_W'($urandom_range(257, 511));
      2: rows_value = 9'd0;
      default: rows_value = ROWS_W'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 9))
      0: cols_value = 7'd0;
      1: cols_value = COLS_W'($urandom_range(65, 127));
      2: cols_value = 7'd64;
      default: cols_value = COLS_W'($urandom_range(1, 64));
    endcase
    set_instance_size(rows_value, cols_value);
    span     = (cols_effective() == 0) ? COLUMN_SLOTS : cols_effective();
    row_span = (rows_effective() == 0) ? ROW_SLOTS : rows_effective();
    case ($urandom_range(0, 4))
      0: density = 0;
      1: density = 25;
      2: density = 50;
      3: density = 90;
      default: density = 100;
    endcase
    tx_gaps_on   = ($urandom_range(0, 3) != 0);
    rx_stalls_on = ($urandom_range(0, 3) != 0);

    // A sweep over every column in use reaches full and empty selections.
    if ($urandom_range(0, 3) == 0) begin
      for (int c = 0; c < span; c++) begin
        send_word(REQ_WRITE_SEL, '0, '0, c[COL_IDX_W-1:0],
                  ($urandom_range(0, 99) < density));
        random_items++;
      end
    end

    count = $urandom_range(15, 40);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      col  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, span - 1)
                                          : $urandom_range(0, COLUMN_SLOTS - 1);
      if (pick < 20) begin
        send_word(REQ_LOAD_ROW,
                  ($urandom_range(0, 4) != 0) ? ROW_IDX_W'($urandom_range(0, row_span - 1))
                                              : ROW_IDX_W'($urandom_range(0, 255)),
                  random_row(span), '0, 1'b0);
      end else if (pick < 55) begin
        send_word(REQ_WRITE_SEL, '0, '0, col[COL_IDX_W-1:0],
                  ($urandom_range(0, 99) < density));
      end else if (pick < 80) begin
        send_word(REQ_FULL_EVAL, '0, '0, col[COL_IDX_W-1:0], 1'b0);
      end else begin
        send_word(REQ_FLIP_EVAL, '0, '0, col[COL_IDX_W-1:0], 1'b0);
      end
      random_items++;
      // Now and then the sender pauses until every score is back.
      if ($urandom_range(0, 19) == 0) wait_for_results();
    end
  endtask

  task automatic test_random_phases();
    while (random_items < RANDOM_ITEMS) run_random_phase();
  endtask

  // Result checker: each word taken from the output is compared with the
  // oldest queued score.
  always @(posedge clk) begin
    score_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_scores.size() == 0) begin
        $error("result word 0x%08h arrived with no score pending", m_tdata);
        fail_count++;
      end else begin
        want = pending_scores.pop_front();
        scores_checked++;
        if (m_tdata[8:0] !== want.fitness) begin
          $error("fitness mismatch: expected %0d, got %0d", want.fitness, m_tdata[8:0]);
          fail_count++;
        end
        if (m_tdata[17:9] !== want.uncovered) begin
          $error("uncovered_count mismatch: expected %0d, got %0d",
                 want.uncovered, m_tdata[17:9]);
          fail_count++;
        end
        if (m_tdata[24:18] !== want.chosen) begin
          $error("chosen_count mismatch: expected %0d, got %0d",
                 want.chosen, m_tdata[24:18]);
          fail_count++;
        end
        if (m_tdata[25] !== want.feasible) begin
          $error("feasible mismatch: expected %0d, got %0d", want.feasible, m_tdata[25]);
          fail_count++;
        end
        if (m_tdata[31:26] !== '0) begin
          $error("zero fill mismatch: expected 0, got 0x%02h", m_tdata[31:26]);
          fail_count++;
        end
      end
    end
  end

  // Output receiver. It stalls at random when allowed, and on request holds
  // off for a long stretch that it counts itself.
  initial begin : output_receiver
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_request) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left = idle_gap();
      end
    end
  end

  // Guard against a hung block; several times the slowest legal run.
  initial begin : run_limit
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : main_sequence
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_ROWS_IN_USE;
    cfg_data  = '0;
    selected_columns = '0;
    cfg_rows = 9'd256;
    cfg_cols = 7'd64;
    for (int r = 0; r < ROW_SLOTS; r++) matrix_rows[r] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_coverage_corners();
    test_count_limits();
    test_output_stall();
    test_random_phases();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d request words and checked %0d scores over %0d instance sizes,",
             requests_sent, scores_checked, sizes_tried);
    $display("from empty to saturated row and column counts, with idling on both streams.");
    if (fail_count == 0 && pending_scores.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
